FILE: sv/obbov_pkg.sv
// Package: field widths, packing offsets and axis codes for the box pair overlap test.
`timescale 1ns / 1ps

package obbov_pkg;

   localparam int COORD_WIDTH = 24;
   localparam int AXIS_WIDTH  = 16;
   localparam int HALF_WIDTH  = COORD_WIDTH - 1;

   // request packing, lowest bits first
   localparam int OFS_X_LSB    = 0;
   localparam int OFS_Y_LSB    = OFS_X_LSB + COORD_WIDTH;
   localparam int A_AXIS_X_LSB = OFS_Y_LSB + COORD_WIDTH;
   localparam int A_AXIS_Y_LSB = A_AXIS_X_LSB + AXIS_WIDTH;
   localparam int A_HALF_X_LSB = A_AXIS_Y_LSB + AXIS_WIDTH;
   localparam int A_HALF_Y_LSB = A_HALF_X_LSB + HALF_WIDTH;
   localparam int B_AXIS_X_LSB = A_HALF_Y_LSB + HALF_WIDTH;
   localparam int B_AXIS_Y_LSB = B_AXIS_X_LSB + AXIS_WIDTH;
   localparam int B_HALF_X_LSB = B_AXIS_Y_LSB + AXIS_WIDTH;
   localparam int B_HALF_Y_LSB = B_HALF_X_LSB + HALF_WIDTH;
   localparam int REQ_BITS     = B_HALF_Y_LSB + HALF_WIDTH;
   localparam int REQ_DATA_W   = ((REQ_BITS + 7) / 8) * 8;

   localparam int AXIS_CODE_W = 3;
   localparam int RSP_BITS    = 1 + AXIS_CODE_W;
   localparam int RSP_DATA_W  = ((RSP_BITS + 7) / 8) * 8;

   // arithmetic widths
   localparam int CPROD_W      = COORD_WIDTH + AXIS_WIDTH;
   localparam int CSUM_W       = CPROD_W + 1;
   localparam int DPROD_W      = 2 * AXIS_WIDTH;
   localparam int DSUM_W       = DPROD_W + 1;
   localparam int CENTER_SHIFT = 14;
   localparam int OWN_SHIFT    = 28;
   localparam int CENTER_W     = CSUM_W + CENTER_SHIFT;
   localparam int EXT_W        = HALF_WIDTH + DSUM_W;
   localparam int OWN_W        = HALF_WIDTH + OWN_SHIFT;
   localparam int REACH_W      = ((EXT_W > OWN_W) ? EXT_W : OWN_W) + 2;
   localparam int CMP_W        = (REACH_W > CENTER_W) ? REACH_W : CENTER_W;

   localparam logic [AXIS_CODE_W-1:0] SEP_A_FIRST  = 3'd0;
   localparam logic [AXIS_CODE_W-1:0] SEP_A_SECOND = 3'd1;
   localparam logic [AXIS_CODE_W-1:0] SEP_B_FIRST  = 3'd2;
   localparam logic [AXIS_CODE_W-1:0] SEP_B_SECOND = 3'd3;
   localparam logic [AXIS_CODE_W-1:0] SEP_NONE     = 3'd4;

   typedef struct packed {
      logic [HALF_WIDTH-1:0] own_half;
      logic [HALF_WIDTH-1:0] half1;
      logic [DSUM_W-1:0]     dot1_mag;
      logic [HALF_WIDTH-1:0] half2;
      logic [DSUM_W-1:0]     dot2_mag;
      logic [CSUM_W-1:0]     center_mag;
   } axis_operands_type;

endpackage

FILE: sv/obbov_axis_test.sv
// One axis of the separating axis test: projected reach and compare, three stages.
`timescale 1ns / 1ps

module obbov_axis_test
   import obbov_pkg::*;
(
   input  logic              clock,
   input  logic              advance,
   input  axis_operands_type operands,
   output logic              separated
);

   logic [EXT_W-1:0]    ext1_ff, ext2_ff;
   logic [OWN_W-1:0]    own_ff;
   logic [CENTER_W-1:0] center4_ff, center5_ff;
   logic [REACH_W-1:0]  reach_in, reach_ff;
   logic                sep_in, sep_ff;

   // stage 4: half lengths times projected axis magnitudes
   always_ff @(posedge clock) begin
      if (advance) begin
         ext1_ff    <= EXT_W'(operands.half1) * EXT_W'(operands.dot1_mag);
         ext2_ff    <= EXT_W'(operands.half2) * EXT_W'(operands.dot2_mag);
         own_ff     <= {operands.own_half, {OWN_SHIFT{1'b0}}};
         center4_ff <= {operands.center_mag, {CENTER_SHIFT{1'b0}}};
      end
   end

   // stage 5: total reach; cannot overflow at these widths
   assign reach_in = REACH_W'(own_ff) + REACH_W'(ext1_ff) + REACH_W'(ext2_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         reach_ff   <= reach_in;
         center5_ff <= center4_ff;
      end
   end

   // stage 6: touching does not separate
   assign sep_in = CMP_W'(center5_ff) > CMP_W'(reach_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         sep_ff <= sep_in;
      end
   end

   assign separated = sep_ff;

endmodule

FILE: sv/obbov_obb_pair_overlap_test_core.sv
// Top level: separating axis overlap test for a pair of oriented rectangles.
`timescale 1ns / 1ps

// Seven-stage pipeline that takes one box pair per cycle when not stalled and returns one
// result per pair. Stages: input products, sums, magnitudes, extent products, reach sums,
// compares, first-axis encode into the output register.
// The whole pipeline advances whenever the output register is empty or being taken, and
// req_tready is high exactly then; a stall holds every stage. No state is kept between pairs.
module obb_pair_overlap_test_core
   import obbov_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // offset_x, offset_y, a_axis_x, a_axis_y, a_half_x, a_half_y,
   // b_axis_x, b_axis_y, b_half_x, b_half_y, zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // overlap, separating_axis, zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic advance;
   logic [6:0] valid_ff;

   logic signed [COORD_WIDTH-1:0] dx, dy;
   logic signed [AXIS_WIDTH-1:0]  a1x, a1y, b1x, b1y;
   logic [HALF_WIDTH-1:0]         ha1, ha2, hb1, hb2;

   assign dx  = req_tdata[OFS_X_LSB +: COORD_WIDTH];
   assign dy  = req_tdata[OFS_Y_LSB +: COORD_WIDTH];
   assign a1x = req_tdata[A_AXIS_X_LSB +: AXIS_WIDTH];
   assign a1y = req_tdata[A_AXIS_Y_LSB +: AXIS_WIDTH];
   assign ha1 = req_tdata[A_HALF_X_LSB +: HALF_WIDTH];
   assign ha2 = req_tdata[A_HALF_Y_LSB +: HALF_WIDTH];
   assign b1x = req_tdata[B_AXIS_X_LSB +: AXIS_WIDTH];
   assign b1y = req_tdata[B_AXIS_Y_LSB +: AXIS_WIDTH];
   assign hb1 = req_tdata[B_HALF_X_LSB +: HALF_WIDTH];
   assign hb2 = req_tdata[B_HALF_Y_LSB +: HALF_WIDTH];

   assign advance    = !valid_ff[6] || rsp_tready;
   assign req_tready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[5:0], req_tvalid};
      end
   end

   // stage 1: products for the centre projections and the axis dot products
   logic signed [CPROD_W-1:0] dx_a1x_ff, dy_a1y_ff, dy_a1x_ff, dx_a1y_ff;
   logic signed [CPROD_W-1:0] dx_b1x_ff, dy_b1y_ff, dy_b1x_ff, dx_b1y_ff;
   logic signed [DPROD_W-1:0] a1x_b1x_ff, a1y_b1y_ff, a1x_b1y_ff, a1y_b1x_ff;
   logic [HALF_WIDTH-1:0]     ha1_1_ff, ha2_1_ff, hb1_1_ff, hb2_1_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         dx_a1x_ff  <= CPROD_W'(dx) * CPROD_W'(a1x);
         dy_a1y_ff  <= CPROD_W'(dy) * CPROD_W'(a1y);
         dy_a1x_ff  <= CPROD_W'(dy) * CPROD_W'(a1x);
         dx_a1y_ff  <= CPROD_W'(dx) * CPROD_W'(a1y);
         dx_b1x_ff  <= CPROD_W'(dx) * CPROD_W'(b1x);
         dy_b1y_ff  <= CPROD_W'(dy) * CPROD_W'(b1y);
         dy_b1x_ff  <= CPROD_W'(dy) * CPROD_W'(b1x);
         dx_b1y_ff  <= CPROD_W'(dx) * CPROD_W'(b1y);
         a1x_b1x_ff <= DPROD_W'(a1x) * DPROD_W'(b1x);
         a1y_b1y_ff <= DPROD_W'(a1y) * DPROD_W'(b1y);
         a1x_b1y_ff <= DPROD_W'(a1x) * DPROD_W'(b1y);
         a1y_b1x_ff <= DPROD_W'(a1y) * DPROD_W'(b1x);
         ha1_1_ff   <= ha1;
         ha2_1_ff   <= ha2;
         hb1_1_ff   <= hb1;
         hb2_1_ff   <= hb2;
      end
   end

   // stage 2: projections on each axis; second axes are the first turned by +90 degrees
   logic [CSUM_W-1:0]     c0_in, c1_in, c2_in, c3_in, c0_ff, c1_ff, c2_ff, c3_ff;
   logic [DSUM_W-1:0]     p_in, q_in, p_ff, q_ff;
   logic [HALF_WIDTH-1:0] ha1_2_ff, ha2_2_ff, hb1_2_ff, hb2_2_ff;

   assign c0_in = {dx_a1x_ff[CPROD_W-1], dx_a1x_ff} + {dy_a1y_ff[CPROD_W-1], dy_a1y_ff};
   assign c1_in = {dy_a1x_ff[CPROD_W-1], dy_a1x_ff} - {dx_a1y_ff[CPROD_W-1], dx_a1y_ff};
   assign c2_in = {dx_b1x_ff[CPROD_W-1], dx_b1x_ff} + {dy_b1y_ff[CPROD_W-1], dy_b1y_ff};
   assign c3_in = {dy_b1x_ff[CPROD_W-1], dy_b1x_ff} - {dx_b1y_ff[CPROD_W-1], dx_b1y_ff};
   // p is a1.b1 = a2.b2, q is a1.b2 = -(a2.b1)
   assign p_in  = {a1x_b1x_ff[DPROD_W-1], a1x_b1x_ff} + {a1y_b1y_ff[DPROD_W-1], a1y_b1y_ff};
   assign q_in  = {a1y_b1x_ff[DPROD_W-1], a1y_b1x_ff} - {a1x_b1y_ff[DPROD_W-1], a1x_b1y_ff};

   always_ff @(posedge clock) begin
      if (advance) begin
         c0_ff    <= c0_in;
         c1_ff    <= c1_in;
         c2_ff    <= c2_in;
         c3_ff    <= c3_in;
         p_ff     <= p_in;
         q_ff     <= q_in;
         ha1_2_ff <= ha1_1_ff;
         ha2_2_ff <= ha2_1_ff;
         hb1_2_ff <= hb1_1_ff;
         hb2_2_ff <= hb2_1_ff;
      end
   end

   // stage 3: magnitudes
   logic [CSUM_W-1:0]     m0_ff, m1_ff, m2_ff, m3_ff;
   logic [DSUM_W-1:0]     pm_ff, qm_ff;
   logic [HALF_WIDTH-1:0] ha1_3_ff, ha2_3_ff, hb1_3_ff, hb2_3_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         m0_ff    <= c0_ff[CSUM_W-1] ? -c0_ff : c0_ff;
         m1_ff    <= c1_ff[CSUM_W-1] ? -c1_ff : c1_ff;
         m2_ff    <= c2_ff[CSUM_W-1] ? -c2_ff : c2_ff;
         m3_ff    <= c3_ff[CSUM_W-1] ? -c3_ff : c3_ff;
         pm_ff    <= p_ff[DSUM_W-1] ? -p_ff : p_ff;
         qm_ff    <= q_ff[DSUM_W-1] ? -q_ff : q_ff;
         ha1_3_ff <= ha1_2_ff;
         ha2_3_ff <= ha2_2_ff;
         hb1_3_ff <= hb1_2_ff;
         hb2_3_ff <= hb2_2_ff;
      end
   end

   axis_operands_type ops [4];
   logic [3:0]        separated;

   assign ops[0] = '{own_half: ha1_3_ff, half1: hb1_3_ff, dot1_mag: pm_ff,
                     half2: hb2_3_ff, dot2_mag: qm_ff, center_mag: m0_ff};
   assign ops[1] = '{own_half: ha2_3_ff, half1: hb1_3_ff, dot1_mag: qm_ff,
                     half2: hb2_3_ff, dot2_mag: pm_ff, center_mag: m1_ff};
   assign ops[2] = '{own_half: hb1_3_ff, half1: ha1_3_ff, dot1_mag: pm_ff,
                     half2: ha2_3_ff, dot2_mag: qm_ff, center_mag: m2_ff};
   assign ops[3] = '{own_half: hb2_3_ff, half1: ha1_3_ff, dot1_mag: qm_ff,
                     half2: ha2_3_ff, dot2_mag: pm_ff, center_mag: m3_ff};

   // stages 4 to 6
   for (genvar i = 0; i < 4; i++) begin : g_axis
      obbov_axis_test u_axis (
         .clock     (clock),
         .advance   (advance),
         .operands  (ops[i]),
         .separated (separated[i])
      );
   end

   // stage 7: first separating axis in test order
   logic [AXIS_CODE_W-1:0] axis_in, axis_ff;

   always_comb begin
      if (separated[0]) begin
         axis_in = SEP_A_FIRST;
      end else if (separated[1]) begin
         axis_in = SEP_A_SECOND;
      end else if (separated[2]) begin
         axis_in = SEP_B_FIRST;
      end else if (separated[3]) begin
         axis_in = SEP_B_SECOND;
      end else begin
         axis_in = SEP_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         axis_ff <= axis_in;
      end
   end

   assign rsp_tvalid = valid_ff[6];
   assign rsp_tdata  = RSP_DATA_W'({axis_ff, axis_ff == SEP_NONE});

endmodule
